>>> rtl/udtw_pkg.sv
// constants and helpers shared by the uv-distance taper weighting block
package udtw_pkg;

  // distance limit of 400 wavelengths, as a radicand in Q.32
  localparam logic [49:0] FAR_Y = 50'd687194767360000;

  // ceil(2^27 / 5), exact quotient by 5 for values below 2^26
  localparam logic [24:0] DIV5_M = 25'd26843546;

  // ceil(2^24 / k), exact quotient by k for values below 2^20
  localparam logic [24:0] RECIP [17] = '{
    25'd0,
    25'((16777216 + 0) / 1),
    25'((16777216 + 1) / 2),
    25'((16777216 + 2) / 3),
    25'((16777216 + 3) / 4),
    25'((16777216 + 4) / 5),
    25'((16777216 + 5) / 6),
    25'((16777216 + 6) / 7),
    25'((16777216 + 7) / 8),
    25'((16777216 + 8) / 9),
    25'((16777216 + 9) / 10),
    25'((16777216 + 10) / 11),
    25'((16777216 + 11) / 12),
    25'((16777216 + 12) / 13),
    25'((16777216 + 13) / 14),
    25'((16777216 + 14) / 15),
    25'((16777216 + 15) / 16)
  };

  // truncated taylor terms of exp(1) in q.31
  localparam logic [63:0] ET0  = 64'd1 << 31;
  localparam logic [63:0] ET1  = ET0 / 1;
  localparam logic [63:0] ET2  = ET1 / 2;
  localparam logic [63:0] ET3  = ET2 / 3;
  localparam logic [63:0] ET4  = ET3 / 4;
  localparam logic [63:0] ET5  = ET4 / 5;
  localparam logic [63:0] ET6  = ET5 / 6;
  localparam logic [63:0] ET7  = ET6 / 7;
  localparam logic [63:0] ET8  = ET7 / 8;
  localparam logic [63:0] ET9  = ET8 / 9;
  localparam logic [63:0] ET10 = ET9 / 10;
  localparam logic [63:0] ET11 = ET10 / 11;
  localparam logic [63:0] ET12 = ET11 / 12;
  localparam logic [63:0] ET13 = ET12 / 13;
  localparam logic [63:0] ET14 = ET13 / 14;
  localparam logic [63:0] ET15 = ET14 / 15;
  localparam logic [63:0] ET16 = ET15 / 16;
  localparam logic [63:0] E1 = ET0 + ET1 + ET2 + ET3 + ET4 + ET5 + ET6 + ET7 + ET8
                             + ET9 + ET10 + ET11 + ET12 + ET13 + ET14 + ET15 + ET16;

  // exp(-1) in q.31, rounded
  localparam logic [63:0] EM1 = ((64'd1 << 62) + (E1 >> 1)) / E1;

  localparam int unsigned EXP_TERMS = 16;

  // floor(b * 2^13 / 5) for a remainder b of a division by 5
  function automatic logic [12:0] frac20(input logic [2:0] b);
    logic [12:0] f;
    case (b)
      3'd0:    f = 13'd0;
      3'd1:    f = 13'd1638;
      3'd2:    f = 13'd3276;
      3'd3:    f = 13'd4915;
      3'd4:    f = 13'd6553;
      default: f = 13'd0;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/udtw_div.sv
// pipelined restoring divider, one quotient bit per stage
module udtw_div #(
  parameter int unsigned DEN_W = 33,
  parameter int unsigned QUO_W = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DEN_W+QUO_W-1:0]   num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [QUO_W-1:0]         quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W:0]   trial;
    logic             qbit;

    if (s == 0) begin : g_first
      assign rem_in = num_i[DEN_W+QUO_W-1:QUO_W];
      assign low_in = num_i[QUO_W-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign qbit  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (qbit) begin
          rem_q[s] <= DEN_W'(trial - {1'b0, den_in});
        end else begin
          rem_q[s] <= trial[DEN_W-1:0];
        end
        low_q[s] <= {low_in[QUO_W-2:0], qbit};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = low_q[QUO_W-1];

endmodule

>>> rtl/uv_distance_taper_weighting.sv
// uv-distance taper weighting, top level
//
// Input channel: one word per baseline (u, v, eight samples, last flag) on
// in_valid_i; the block holds in_stall_o high while it cannot take a word.
// Output channel: one word per input word, in order, on out_valid_o with the
// scaled samples, the applied taper factor and the last flag; the receiver
// raises out_stall_i to hold the word.
// Configuration: freq_hz_i is written by cfg_valid_i (cfg_ready_o is always
// high); the user must write it only while no baseline is in flight, as the
// block does not enforce this. Words pass from acceptance to out_valid_o
// through square root, exponential series, both dividers and exp(-1) powers.
// Throughput is one baseline per cycle while the output word is not stalled.
// When the output word is stalled the whole pipeline holds, so in_stall_o
// follows out_stall_i while an output word is waiting.
// Reset clears the valid bits and the frequency register; data registers
// are not reset.
module uv_distance_taper_weighting #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [30:0]                   freq_hz_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            u_time_i,
  input  logic signed [31:0]            v_time_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_3_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_4_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_5_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_6_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_7_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] scaled_0_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_1_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_2_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_3_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_4_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_5_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_6_o,
  output logic signed [SAMPLE_BITS-1:0] scaled_7_o,
  output logic [16:0]                   taper_factor_o,
  output logic                          last_out_o
);
  import udtw_pkg::*;

  localparam int unsigned NS   = 8;
  localparam int unsigned RT_N = 25;
  localparam int unsigned EX_N = 3 * EXP_TERMS;
  localparam int unsigned D1_N = 32;
  localparam int unsigned PW_N = 20;
  localparam int unsigned D2_N = 17;
  localparam int unsigned ST_M = 5 + RT_N + 2 + EX_N + D1_N + PW_N + 2 + D2_N;
  localparam int unsigned LAT  = ST_M + 2;
  localparam int unsigned PW   = SAMPLE_BITS + 17;

  typedef struct packed {
    logic [33:0] sum;
    logic [30:0] r;
    logic [4:0]  n;
  } ex_side_t;

  logic en;

  // frequency squared
  logic [61:0] f2_d, f2_q;
  assign cfg_ready_o = 1'b1;
  assign f2_d = 62'(freq_hz_i) * 62'(freq_hz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_q <= '0;
    end else if (cfg_valid_i) begin
      f2_q <= f2_d;
    end
  end

  // valid, last and sample lines
  logic [LAT-1:0] vld_q;
  logic [LAT-1:0] last_q;
  logic [NS-1:0][SAMPLE_BITS-1:0] smp_in;
  logic [NS-1:0][SAMPLE_BITS-1:0] smp_q [ST_M];

  assign out_valid_o = vld_q[LAT-1];
  assign in_stall_o  = vld_q[LAT-1] & out_stall_i;
  assign en          = ~in_stall_o;

  assign smp_in = {sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                   sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q   <= {last_q[LAT-2:0], last_in_i};
      smp_q[0] <= smp_in;
      for (int i = 1; i < ST_M; i++) begin
        smp_q[i] <= smp_q[i-1];
      end
    end
  end

  // squared distance times frequency squared
  logic [31:0]  au, av;
  logic [63:0]  sqa_q, sqb_q, s_q;
  logic [63:0]  pp_ll_q, pp_lh_q;
  logic [61:0]  pp_hl_q, pp_hh_q;
  logic [127:0] p_q;
  logic [49:0]  y_q;
  logic         far;

  assign au  = u_time_i[31] ? 32'(~u_time_i + 32'sd1) : 32'(u_time_i);
  assign av  = v_time_i[31] ? 32'(~v_time_i + 32'sd1) : 32'(v_time_i);
  assign far = (p_q[127:80] > 48'd160000) ||
               ((p_q[127:80] == 48'd160000) && (|p_q[79:0]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q   <= 64'(au) * 64'(au);
      sqb_q   <= 64'(av) * 64'(av);
      s_q     <= sqa_q + sqb_q;
      pp_ll_q <= 64'(f2_q[31:0]) * 64'(s_q[31:0]);
      pp_lh_q <= 64'(f2_q[31:0]) * 64'(s_q[63:32]);
      pp_hl_q <= 62'(f2_q[61:32]) * 62'(s_q[31:0]);
      pp_hh_q <= 62'(f2_q[61:32]) * 62'(s_q[63:32]);
      p_q     <= 128'(pp_ll_q) + (128'(pp_lh_q) << 32) + (128'(pp_hl_q) << 32)
               + (128'(pp_hh_q) << 64);
      y_q     <= far ? FAR_Y : p_q[97:48];
    end
  end

  // square root, one root bit per stage
  logic [49:0] rad_q  [RT_N];
  logic [26:0] rem_q  [RT_N];
  logic [24:0] root_q [RT_N];

  for (genvar j = 0; j < RT_N; j++) begin : g_sqrt
    logic [49:0] rad_in;
    logic [26:0] rem_in;
    logic [24:0] root_in;
    logic [28:0] rem2, test;

    if (j == 0) begin : g_first
      assign rad_in  = y_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign rem2 = {rem_in, rad_in[49:48]};
    assign test = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[j] <= {rad_in[47:0], 2'b00};
        if (rem2 >= test) begin
          rem_q[j]  <= 27'(rem2 - test);
          root_q[j] <= {root_in[23:0], 1'b1};
        end else begin
          rem_q[j]  <= rem2[26:0];
          root_q[j] <= {root_in[23:0], 1'b0};
        end
      end
    end
  end

  // d / 20 in q.31, split into whole part and fraction
  logic [49:0] q5_prod;
  logic [22:0] a5_q;
  logic [24:0] dq_q;
  logic [24:0] b5_full;
  logic [35:0] t_val;
  logic [4:0]  n_q;
  logic [30:0] r_q;

  assign q5_prod = 50'(root_q[RT_N-1]) * 50'(DIV5_M);
  assign b5_full = dq_q - 25'(a5_q) * 25'd5;
  assign t_val   = {a5_q, 13'b0} + 36'(frac20(b5_full[2:0]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      a5_q <= q5_prod[49:27];
      dq_q <= root_q[RT_N-1];
      n_q  <= t_val[35:31];
      r_q  <= t_val[30:0];
    end
  end

  // exp(r) series, three stages per term
  logic [62:0] ex_prod_q [EXP_TERMS];
  logic [15:0] ex_a1_q   [EXP_TERMS];
  logic [3:0]  ex_r1_q   [EXP_TERMS];
  logic [15:0] ex_ql_q   [EXP_TERMS];
  logic [31:0] ex_term_q [EXP_TERMS];
  ex_side_t    sa_q [EXP_TERMS];
  ex_side_t    sb_q [EXP_TERMS];
  ex_side_t    sc_q [EXP_TERMS];

  for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_exp
    logic [31:0] term_in;
    ex_side_t    side_in;
    logic [31:0] q;
    logic [40:0] mh;
    logic [15:0] a1;
    logic [19:0] a1k;
    logic [19:0] lo;
    logic [44:0] ml;
    logic [15:0] a2;

    if (k == 1) begin : g_first
      assign term_in = 32'h8000_0000;
      assign side_in = '{sum: 34'h0_8000_0000, r: r_q, n: n_q};
    end else begin : g_next
      assign term_in = ex_term_q[k-2];
      assign side_in = sc_q[k-2];
    end

    assign q   = ex_prod_q[k-1][62:31];
    assign mh  = 41'(q[31:16]) * 41'(RECIP[k]);
    assign a1  = mh[39:24];
    assign a1k = 20'(a1) * 20'(k);
    assign lo  = {ex_r1_q[k-1], ex_ql_q[k-1]};
    assign ml  = 45'(lo) * 45'(RECIP[k]);
    assign a2  = ml[39:24];

    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_prod_q[k-1] <= 63'(term_in) * 63'(side_in.r);
        sa_q[k-1]      <= side_in;
        ex_a1_q[k-1]   <= a1;
        ex_r1_q[k-1]   <= 4'(20'(q[31:16]) - a1k);
        ex_ql_q[k-1]   <= q[15:0];
        sb_q[k-1]      <= sa_q[k-1];
        ex_term_q[k-1] <= {ex_a1_q[k-1], a2};
        sc_q[k-1]      <= '{sum: sb_q[k-1].sum + 34'({ex_a1_q[k-1], a2}),
                            r: sb_q[k-1].r, n: sb_q[k-1].n};
      end
    end
  end

  // exp(-r) = 2^62 / exp(r), rounded
  logic [32:0] er;
  logic [64:0] num1;
  logic [31:0] e_div;
  logic [4:0]  nd_q [D1_N];

  assign er   = sc_q[EXP_TERMS-1].sum[32:0];
  assign num1 = (65'd1 << 62) + 65'(er >> 1);

  udtw_div #(
    .DEN_W (33),
    .QUO_W (D1_N)
  ) u_div_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num1),
    .den_i (er),
    .quo_o (e_div)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q[0] <= sc_q[EXP_TERMS-1].n;
      for (int i = 1; i < D1_N; i++) begin
        nd_q[i] <= nd_q[i-1];
      end
    end
  end

  // whole part: n multiplications by exp(-1)
  logic [31:0] pw_e_q [PW_N];
  logic [4:0]  pw_n_q [PW_N];

  for (genvar i = 0; i < PW_N; i++) begin : g_pow
    logic [31:0] e_in;
    logic [4:0]  n_in;
    logic [61:0] mul;

    if (i == 0) begin : g_first
      assign e_in = e_div;
      assign n_in = nd_q[D1_N-1];
    end else begin : g_next
      assign e_in = pw_e_q[i-1];
      assign n_in = pw_n_q[i-1];
    end

    assign mul = 62'(e_in) * 62'(EM1[29:0]) + (62'd1 << 30);

    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_n_q[i] <= n_in;
        if (5'(i) < n_in) begin
          pw_e_q[i] <= {1'b0, mul[61:31]};
        end else begin
          pw_e_q[i] <= e_in;
        end
      end
    end
  end

  // g = 1.8 * e rounded, denominator 1 + g
  logic [34:0] gx;
  logic [42:0] gm1;
  logic [17:0] ga1;
  logic [17:0] ga1_q;
  logic [2:0]  gr_q;
  logic [16:0] gxl_q;
  logic [44:0] gm2;
  logic [34:0] g_val;
  logic [32:0] den_q;
  logic [49:0] num2;
  logic [16:0] fac;

  assign gx    = 35'(pw_e_q[PW_N-1]) * 35'd9 + 35'd2;
  assign gm1   = 43'(gx[34:17]) * 43'(RECIP[5]);
  assign ga1   = gm1[41:24];
  assign gm2   = 45'({gr_q, gxl_q}) * 45'(RECIP[5]);
  assign g_val = {ga1_q, 17'b0} + 35'(gm2[40:24]);
  assign num2  = (50'd1 << 47) + 50'(den_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ga1_q <= ga1;
      gr_q  <= 3'(gx[34:17] - 18'(ga1 * 18'd5));
      gxl_q <= gx[16:0];
      den_q <= 33'(36'h0_8000_0000 + 36'(g_val));
    end
  end

  udtw_div #(
    .DEN_W (33),
    .QUO_W (D2_N)
  ) u_div_fac (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num2),
    .den_i (den_q),
    .quo_o (fac)
  );

  // sample scaling and output word
  logic [PW-1:0]          prod_q [NS];
  logic [NS-1:0]          neg_q;
  logic [16:0]            fac_q;
  logic [SAMPLE_BITS-1:0] scl_q  [NS];
  logic [16:0]            fac_out_q;

  for (genvar i = 0; i < NS; i++) begin : g_scale
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PW-1:0]          rnd;
    logic [SAMPLE_BITS-1:0] qv;

    assign smp = smp_q[ST_M-1][i];
    assign mag = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(~smp + 1'b1) : smp;
    assign rnd = prod_q[i] + PW'(1 << 15);
    assign qv  = rnd[SAMPLE_BITS+15:16];

    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[i] <= PW'(mag) * PW'(fac);
        neg_q[i]  <= smp[SAMPLE_BITS-1];
        scl_q[i]  <= neg_q[i] ? SAMPLE_BITS'(~qv + 1'b1) : qv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fac_q     <= fac;
      fac_out_q <= fac_q;
    end
  end

  assign scaled_0_o     = scl_q[0];
  assign scaled_1_o     = scl_q[1];
  assign scaled_2_o     = scl_q[2];
  assign scaled_3_o     = scl_q[3];
  assign scaled_4_o     = scl_q[4];
  assign scaled_5_o     = scl_q[5];
  assign scaled_6_o     = scl_q[6];
  assign scaled_7_o     = scl_q[7];
  assign taper_factor_o = fac_out_q;
  assign last_out_o     = last_q[LAT-1];

endmodule
